// ===== src/xte_pkg.sv =====
// Package for the XML text escaper: item types, classification codes and
// the entity spelling table. No dependencies.
package xte_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_QUOT,
        KIND_APOS
    } kind_t;

    // Classified item passed from the front to the back through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic       string_end;
    } cls_item_t;

    // Number of output bytes for one classified item
    function automatic logic [2:0] ent_len(input kind_t kind);
        logic [2:0] len;
        case (kind)
            KIND_AMP:  len = 3'd5;
            KIND_LT:   len = 3'd4;
            KIND_GT:   len = 3'd4;
            KIND_QUOT: len = 3'd6;
            KIND_APOS: len = 3'd6;
            default:   len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte idx of the entity spelling for kind
    function automatic logic [7:0] ent_char(input kind_t kind, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h3B; // ';' closes every entity
        case (kind)
            KIND_AMP:
            begin
                case (idx)
                    3'd0:    c = 8'h26;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6D;
                    3'd3:    c = 8'h70;
                    default: c = 8'h3B;
                endcase
            end
            KIND_LT:
            begin
                case (idx)
                    3'd0:    c = 8'h26;
                    3'd1:    c = 8'h6C;
                    3'd2:    c = 8'h74;
                    default: c = 8'h3B;
                endcase
            end
            KIND_GT:
            begin
                case (idx)
                    3'd0:    c = 8'h26;
                    3'd1:    c = 8'h67;
                    3'd2:    c = 8'h74;
                    default: c = 8'h3B;
                endcase
            end
            KIND_QUOT:
            begin
                case (idx)
                    3'd0:    c = 8'h26;
                    3'd1:    c = 8'h71;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h6F;
                    3'd4:    c = 8'h74;
                    default: c = 8'h3B;
                endcase
            end
            KIND_APOS:
            begin
                case (idx)
                    3'd0:    c = 8'h26;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h70;
                    3'd3:    c = 8'h6F;
                    3'd4:    c = 8'h73;
                    default: c = 8'h3B;
                endcase
            end
            default:   c = 8'h3B;
        endcase
        return c;
    endfunction

endpackage

// ===== src/xte_front.sv =====
// Front end of the XML text escaper: classifies each input byte and tracks
// the UTF-8 continuation skip count. Depends on xte_pkg.
module xte_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  xte_pkg::in_item_t    raw,
    input  logic                 q_full,
    output logic                 q_push,
    output xte_pkg::cls_item_t   q_item
);
    import xte_pkg::*;

    logic [1:0] skip_reg;
    logic [1:0] skip_next;
    kind_t      kind;

    always_comb
    begin
        kind      = KIND_PLAIN;
        skip_next = skip_reg;
        if (skip_reg != 2'd0)
        begin
            skip_next = skip_reg - 2'd1;
        end
        else if (!raw.data_byte[7])
        begin
            case (raw.data_byte)
                8'h26:   kind = KIND_AMP;
                8'h3C:   kind = KIND_LT;
                8'h3E:   kind = KIND_GT;
                8'h22:   kind = KIND_QUOT;
                8'h27:   kind = KIND_APOS;
                default: kind = KIND_PLAIN;
            endcase
        end
        else if (raw.data_byte < 8'hE0)
        begin
            skip_next = 2'd1;
        end
        else if (raw.data_byte < 8'hF0)
        begin
            skip_next = 2'd2;
        end
        else
        begin
            skip_next = 2'd3;
        end
        // a cut-short sequence never leaks into the next string
        if (raw.string_end)
        begin
            skip_next = 2'd0;
        end
    end

    assign q_push            = push && !q_full;
    assign q_item.data_byte  = raw.data_byte;
    assign q_item.kind       = kind;
    assign q_item.string_end = raw.string_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 2'd0;
        end
        else if (q_push)
        begin
            skip_reg <= skip_next;
        end
    end

endmodule

// ===== src/xte_queue.sv =====
// Short queue of classified items between front and back of the escaper.
// Depends on xte_pkg.
module xte_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  xte_pkg::cls_item_t   wr_item,
    output logic                 q_full,
    input  logic                 rd_en,
    output xte_pkg::cls_item_t   rd_item,
    output logic                 q_empty
);
    import xte_pkg::*;

    cls_item_t      mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_wr;
    logic           do_rd;

    assign q_full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/xte_back.sv =====
// Back end of the XML text escaper: expands each classified item into its
// output bytes and holds one result in an output register. Depends on xte_pkg.
module xte_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  xte_pkg::cls_item_t   q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output xte_pkg::out_item_t   esc
);
    import xte_pkg::*;

    logic       out_valid_reg;
    out_item_t  out_reg;
    logic [2:0] idx_reg;
    logic [2:0] len;
    logic       load;
    logic       fin;
    logic [7:0] byte_sel;

    assign len      = ent_len(q_item.kind);
    assign fin      = (idx_reg == len - 3'd1);
    // output slot frees up when empty or being taken this cycle
    assign load     = (!out_valid_reg || pop) && !q_empty;
    assign q_pop    = load && fin;
    assign byte_sel = (q_item.kind == KIND_PLAIN) ? q_item.data_byte
                                                  : ent_char(q_item.kind, idx_reg);
    assign empty    = !out_valid_reg;
    assign esc      = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte    <= byte_sel;
            out_reg.run_last    <= fin;
            out_reg.string_done <= fin && q_item.string_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= fin ? 3'd0 : idx_reg + 3'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/xml_text_escaper.sv =====
// Top level of the XML text escaper: front classifier, item queue and back
// expander. Depends on xte_pkg, xte_front, xte_queue and xte_back.
//
// Bytes go in on the raw side (push/full) and escaped bytes come out on the
// esc side (empty/pop). A plain byte gives one output byte; '&' gives five,
// '<' and '>' four, '"' and '\'' six; the back end emits one byte per cycle
// unless its output register is held. Plain text flows at one byte per clock
// while the receiver pops, and a four-deep item queue keeps input flowing
// during entity expansion until it fills.
module xml_text_escaper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  xte_pkg::in_item_t    raw,
    output logic                 empty,
    input  logic                 pop,
    output xte_pkg::out_item_t   esc
);
    import xte_pkg::*;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    cls_item_t wr_item;
    cls_item_t rd_item;

    assign full = q_full;

    xte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .raw    (raw),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (wr_item)
    );

    xte_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (rd_item),
        .q_empty (q_empty)
    );

    xte_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (rd_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .esc     (esc)
    );

endmodule

// ===== tb/tb_xml_text_escaper.sv =====
// Testbench for xml_text_escaper: drives text strings through the push/full side and
// checks every escaped byte against a local predictor. Depends on xte_pkg and the RTL.
module tb_xml_text_escaper;
    timeunit 1ns;
    timeprecision 1ps;

    import xte_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 13;
    localparam int RANDOM_ITEMS = 125;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AFTER   = 30;
    localparam int SETTLE       = 20;
    localparam int STALL_LIMIT  = 3000;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_AMP  = 8'h26;  // &
    localparam logic [7:0] CH_LT   = 8'h3C;  // <
    localparam logic [7:0] CH_GT   = 8'h3E;  // >
    localparam logic [7:0] CH_QUOT = 8'h22;  // "
    localparam logic [7:0] CH_APOS = 8'h27;  // '
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'h80;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] CONT_MAX  = 8'hBF;

    class escape_scoreboard;
        out_item_t   expected_bytes[$];
        logic [1:0]  cont_left;
        int          mismatches;

        function new();
            cont_left  = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Work out the escaped bytes that one accepted text byte produces
        function void note_byte(in_item_t it);
            string     ent;
            int        n;
            out_item_t r;
            ent = "";
            if (cont_left != 0)
                cont_left = cont_left - 2'd1;
            else if (it.data_byte < LEAD2_MIN)
            begin
                case (it.data_byte)
                    CH_AMP:  ent = "&amp;";
                    CH_LT:   ent = "&lt;";
                    CH_GT:   ent = "&gt;";
                    CH_QUOT: ent = "&quot;";
                    CH_APOS: ent = "&apos;";
                    default: ent = "";
                endcase
            end
            else if (it.data_byte < LEAD3_MIN)
                cont_left = 2'd1;
            else if (it.data_byte < LEAD4_MIN)
                cont_left = 2'd2;
            else
                cont_left = 2'd3;

            n = (ent.len() == 0) ? 1 : ent.len();
            for (int k = 0; k < n; k++)
            begin
                r.out_byte    = (ent.len() == 0) ? it.data_byte : ent[k];
                r.run_last    = (k == n - 1);
                r.string_done = (k == n - 1) && it.string_end;
                expected_bytes.push_back(r);
            end
            // a cut-short sequence must not leak into the next string
            if (it.string_end)
                cont_left = '0;
        endfunction

        task check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %h", got.out_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b on byte %h",
                                          got.run_last, want.run_last, want.out_byte));
            if (got.string_done !== want.string_done)
                report_mismatch($sformatf("string_done %b, want %b on byte %h",
                                          got.string_done, want.string_done, want.out_byte));
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  raw;
    logic      empty;
    logic      pop;
    out_item_t esc;

    escape_scoreboard sb;
    in_item_t         text_items[$];
    bit               rx_holding;
    bit               tx_burst;
    bit               rx_burst;
    int               results_taken;
    int               stall_cycles;

    xml_text_escaper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .raw   (raw),
        .empty (empty),
        .pop   (pop),
        .esc   (esc)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Ends the run if neither side moves an item for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task add_item(logic [7:0] b, logic e);
        in_item_t it;
        it.data_byte  = b;
        it.string_end = e;
        text_items.push_back(it);
    endtask

    // One random string: mostly specials, ASCII and UTF-8 sequences, some noise,
    // sometimes cut in the middle of a sequence
    task automatic add_random_string();
        logic [7:0] bytes[$];
        int         target;
        int         ncont;
        logic [7:0] lead;
        target = $urandom_range(1, 12);
        while (bytes.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    case ($urandom_range(0, 4))
                        0: bytes.push_back(CH_AMP);
                        1: bytes.push_back(CH_LT);
                        2: bytes.push_back(CH_GT);
                        3: bytes.push_back(CH_QUOT);
                        default: bytes.push_back(CH_APOS);
                    endcase
                end
                4, 5: bytes.push_back(8'($urandom_range(0, 127)));
                6, 7:
                begin
                    case ($urandom_range(0, 2))
                        0: lead = 8'($urandom_range(8'hC0, 8'hDF));
                        1: lead = 8'($urandom_range(8'hE0, 8'hEF));
                        default: lead = 8'($urandom_range(8'hF0, 8'hFF));
                    endcase
                    ncont = (lead < LEAD3_MIN) ? 1 : (lead < LEAD4_MIN) ? 2 : 3;
                    bytes.push_back(lead);
                    for (int k = 0; k < ncont; k++)
                    begin
                        // occasionally a special char sits where a continuation belongs
                        if ($urandom_range(0, 5) == 0)
                            bytes.push_back(CH_AMP);
                        else
                            bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    end
                end
                8: bytes.push_back(8'($urandom_range(0, 255)));
                default: bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            while (bytes.size() > target)
                void'(bytes.pop_back());
        for (int k = 0; k < bytes.size(); k++)
            add_item(bytes[k], k == bytes.size() - 1);
    endtask

    task drive_item(in_item_t it, int gap);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        raw  = it;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(it);
        @(negedge clk);
    endtask

    task take_result(int gap);
        if (gap > 0)
        begin
            pop = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pop = 1'b1;
        do
            @(posedge clk);
        while (empty);
        sb.check_byte(esc);
        results_taken++;
        @(negedge clk);
    endtask

    initial
    begin
        int base;
        sb            = new();
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        raw           = '0;
        rx_holding    = 1'b0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        results_taken = 0;

        // directed: every entity, byte extremes, continuation handling, truncation
        add_item(CH_AMP, 1'b0);
        add_item(CH_LT, 1'b0);
        add_item(CH_GT, 1'b0);
        add_item(CH_QUOT, 1'b0);
        add_item(CH_APOS, 1'b0);
        add_item(CH_NUL, 1'b0);
        add_item(CH_DEL, 1'b1);
        add_item(8'hC3, 1'b0);
        add_item(CH_AMP, 1'b0);
        add_item(CH_LT, 1'b0);
        add_item(8'hE2, 1'b0);
        add_item(CH_QUOT, 1'b0);
        add_item(CH_APOS, 1'b0);
        add_item(CH_GT, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(LEAD2_MIN, 1'b0);
        add_item(CH_AMP, 1'b0);
        add_item(CONT_MAX, 1'b0);
        add_item(CH_AMP, 1'b1);
        add_item(LEAD2_MIN, 1'b0);
        add_item(CH_A, 1'b0);
        add_item(8'hEF, 1'b1);
        add_item(CH_LT, 1'b0);
        add_item(8'hDF, 1'b0);
        add_item(LEAD4_MIN, 1'b1);

        base = text_items.size();
        while (text_items.size() < base + RANDOM_ITEMS)
            add_random_string();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        fork
            forever
            begin
                if (results_taken == HOLD_AFTER && !rx_holding)
                begin
                    // long receiver hold-off so the queue fills and full rises
                    rx_holding = 1'b1;
                    pop = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    rx_holding = 1'b0;
                end
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                take_result(draw_gap(rx_burst));
            end
        join_none

        foreach (text_items[i])
        begin
            if ($urandom_range(0, 15) == 0)
                tx_burst = !tx_burst;
            drive_item(text_items[i], draw_gap(tx_burst || rx_holding));
        end
        push = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
